[design/tcw_pkg.sv]
package tcw_pkg;

   // default grid size
   localparam int DEF_COLS = 80;
   localparam int DEF_ROWS = 25;

   // character and attribute codes
   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] NULL_CHAR  = 8'h00;
   localparam logic [7:0] NL_CHAR    = 8'd10;
   localparam logic [7:0] CR_CHAR    = 8'd13;
   localparam logic [7:0] RESET_ATTR = 8'h07;

   // command codes of the request channel
   localparam logic [1:0] CMD_PUT       = 2'd0;
   localparam logic [1:0] CMD_BACKSPACE = 2'd1;
   localparam logic [1:0] CMD_CLEAR     = 2'd2;

   // controller states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_BS_NULL,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_FILL,
      ST_REPORT,
      ST_RESULT
   } state_type;

   // cell write source
   typedef enum logic [2:0] {
      WR_NONE,
      WR_CHAR,
      WR_NULL,
      WR_BLANK,
      WR_INIT,
      WR_COPY
   } wr_sel_type;

   // cell read address source
   typedef enum logic [1:0] {
      RD_SRC,
      RD_SCAN,
      RD_REPORT
   } rd_sel_type;

   // cursor update
   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_ADVANCE,
      CUR_NEWLINE,
      CUR_BACK,
      CUR_UP,
      CUR_SETCOL,
      CUR_SCAN_DEC
   } cur_op_type;

   // sweep index update
   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_BOTTOM,
      IDX_INC
   } idx_op_type;

   // controller to datapath
   typedef struct packed {
      logic       req_ready;
      logic       req_load;
      wr_sel_type wr_sel;
      rd_sel_type rd_sel;
      cur_op_type cur_op;
      idx_op_type idx_op;
      logic       out_load;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       req_valid;
      logic [1:0] cmd;
      logic       is_newline;
      logic       line_empty;
      logic       col_zero;
      logic       row_zero;
      logic       col_last;
      logic       row_last;
      logic       scan_hit;
      logic       scan_at_one;
      logic       idx_copy_end;
      logic       idx_end;
      logic       out_full;
   } ctl_status_type;

endpackage

[design/tcw_req_if.sv]
interface tcw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [7:0]  char_code;
   logic        line_empty;
   logic [10:0] read_addr;

   modport source (output valid, cmd, char_code, line_empty, read_addr, input ready);
   modport sink (input valid, cmd, char_code, line_empty, read_addr, output ready);
endinterface

[design/tcw_rsp_if.sv]
interface tcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  cursor_col;
   logic [4:0]  cursor_row;
   logic [10:0] cursor_pos;
   logic [7:0]  read_char;
   logic [7:0]  read_attr;

   modport source (output valid, cursor_col, cursor_row, cursor_pos, read_char, read_attr,
                   input ready);
   modport sink (input valid, cursor_col, cursor_row, cursor_pos, read_char, read_attr,
                 output ready);
endinterface

[design/tcw_csr_if.sv]
interface tcw_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink (input valid, wdata, output ready);
endinterface

[design/text_console_writer_top.sv]
// Backspace at column 0 scans the previous row backwards cell by cell; scroll and clear
// sweep the cell store one cell at a time (single-port sweep).
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous; cursor 0, attribute 7, then a blanking pass over all cells (no requests).
module text_console_writer_top
   import tcw_pkg::*;
#(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS
) (
   input logic       clock,
   input logic       reset,
   tcw_req_if.sink   req_ch,
   tcw_rsp_if.source rsp_ch,
   tcw_csr_if.sink   csr_ch
);

   ctl_cmd_type    ctl_cmd;
   ctl_status_type ctl_status;

   // command sequencer
   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .ctl_status (ctl_status),
      .ctl_cmd    (ctl_cmd)
   );

   // cell store, cursor and result register
   tcw_datapath #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .ctl_cmd    (ctl_cmd),
      .ctl_status (ctl_status)
   );

endmodule

[design/tcw_datapath.sv]
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS
) (
   input  logic           clock,
   input  logic           reset,
   tcw_req_if.sink        req_ch,
   tcw_rsp_if.source      rsp_ch,
   tcw_csr_if.sink        csr_ch,
   input  ctl_cmd_type    ctl_cmd,
   output ctl_status_type ctl_status
);

   localparam int CELLS   = COLS * ROWS;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int CW      = $clog2(COLS);
   localparam int RW      = $clog2(ROWS);

   localparam logic [CW-1:0]      COL_LAST     = CW'(COLS - 1);
   localparam logic [RW-1:0]      ROW_LAST     = RW'(ROWS - 1);
   localparam logic [CELL_AW-1:0] IDX_COPY_END = CELL_AW'(CELLS - COLS - 1);
   localparam logic [CELL_AW-1:0] IDX_END      = CELL_AW'(CELLS - 1);
   localparam logic [CELL_AW-1:0] IDX_BOT      = CELL_AW'(CELLS - COLS);
   localparam logic [CELL_AW-1:0] COLS_A       = CELL_AW'(COLS);

   // captured request payload
   logic [1:0]  cmd_ff;
   logic [7:0]  char_ff;
   logic        empty_ff;
   logic [10:0] addr_ff;

   // text attribute register
   logic [7:0] attr_ff;

   // cursor and scan column
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] scan_ff, scan_in;

   // sweep index
   logic [CELL_AW-1:0] idx_ff, idx_in;

   // cell store
   logic [15:0] mem [CELLS];
   logic [15:0] rd_data_ff;
   logic [CELL_AW-1:0] rd_addr, wr_addr;
   logic [15:0] wr_data;
   logic wr_en;

   // result register
   logic        rsp_valid_ff;
   logic [6:0]  out_col_ff;
   logic [4:0]  out_row_ff;
   logic [10:0] out_pos_ff;
   logic [7:0]  out_char_ff;
   logic [7:0]  out_attr_ff;

   logic [CELL_AW-1:0] cur_lin, scan_lin;
   logic               addr_ok;
   logic [7:0]         rd_char;

   assign cur_lin  = CELL_AW'(32'(row_ff) * 32'(COLS) + 32'(col_ff));
   assign scan_lin = CELL_AW'(32'(row_ff) * 32'(COLS) + 32'(scan_ff));
   assign addr_ok  = 32'(addr_ff) < 32'(CELLS);
   assign rd_char  = rd_data_ff[7:0];

   // request capture
   assign req_ch.ready = ctl_cmd.req_ready;

   always_ff @(posedge clock) begin
      if (ctl_cmd.req_load) begin
         cmd_ff   <= req_ch.cmd;
         char_ff  <= req_ch.char_code;
         empty_ff <= req_ch.line_empty;
         addr_ff  <= req_ch.read_addr;
      end
   end

   // attribute write, always taken
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else if (csr_ch.valid) begin
         attr_ff <= csr_ch.wdata;
      end
   end

   // cursor update
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      scan_in = scan_ff;
      case (ctl_cmd.cur_op)
         CUR_ADVANCE: begin
            if (col_ff == COL_LAST) begin
               col_in = '0;
               if (row_ff != ROW_LAST) row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         CUR_NEWLINE: begin
            col_in = '0;
            if (row_ff != ROW_LAST) row_in = row_ff + 1'b1;
         end
         CUR_BACK:     col_in = col_ff - 1'b1;
         CUR_UP: begin
            row_in  = row_ff - 1'b1;
            scan_in = COL_LAST;
         end
         CUR_SETCOL:   col_in = ctl_status.scan_hit ? scan_ff : '0;
         CUR_SCAN_DEC: scan_in = scan_ff - 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         scan_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         scan_ff <= scan_in;
      end
   end

   // sweep index update
   always_comb begin
      case (ctl_cmd.idx_op)
         IDX_ZERO:   idx_in = '0;
         IDX_BOTTOM: idx_in = IDX_BOT;
         IDX_INC:    idx_in = idx_ff + 1'b1;
         default:    idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // cell store write and read selection
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = idx_ff;
      case (ctl_cmd.wr_sel)
         WR_CHAR: begin
            wr_addr = cur_lin;
            wr_data = {attr_ff, char_ff};
         end
         WR_NULL: begin
            wr_addr = cur_lin;
            wr_data = {attr_ff, NULL_CHAR};
         end
         WR_BLANK: wr_data = {attr_ff, BLANK_CHAR};
         WR_INIT:  wr_data = {RESET_ATTR, BLANK_CHAR};
         WR_COPY:  wr_data = rd_data_ff;
         default: begin
            wr_en   = 1'b0;
            wr_data = rd_data_ff;
         end
      endcase
   end

   always_comb begin
      case (ctl_cmd.rd_sel)
         RD_SRC:  rd_addr = idx_ff + COLS_A;
         RD_SCAN: rd_addr = scan_lin;
         default: rd_addr = CELL_AW'(addr_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl_cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.out_load) begin
         out_col_ff  <= 7'(col_ff);
         out_row_ff  <= 5'(row_ff);
         out_pos_ff  <= 11'(32'(row_ff) * 32'(COLS) + 32'(col_ff));
         out_char_ff <= addr_ok ? rd_data_ff[7:0] : 8'h00;
         out_attr_ff <= addr_ok ? rd_data_ff[15:8] : 8'h00;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cursor_col = out_col_ff;
   assign rsp_ch.cursor_row = out_row_ff;
   assign rsp_ch.cursor_pos = out_pos_ff;
   assign rsp_ch.read_char  = out_char_ff;
   assign rsp_ch.read_attr  = out_attr_ff;

   // status to controller
   always_comb begin
      ctl_status.req_valid    = req_ch.valid;
      ctl_status.cmd          = cmd_ff;
      ctl_status.is_newline   = (char_ff == NL_CHAR) || (char_ff == CR_CHAR);
      ctl_status.line_empty   = empty_ff;
      ctl_status.col_zero     = (col_ff == '0);
      ctl_status.row_zero     = (row_ff == '0);
      ctl_status.col_last     = (col_ff == COL_LAST);
      ctl_status.row_last     = (row_ff == ROW_LAST);
      ctl_status.scan_hit     = (rd_char != NULL_CHAR) && (rd_char != BLANK_CHAR);
      ctl_status.scan_at_one  = (scan_ff == CW'(1));
      ctl_status.idx_copy_end = (idx_ff == IDX_COPY_END);
      ctl_status.idx_end      = (idx_ff == IDX_END);
      ctl_status.out_full     = rsp_valid_ff && !rsp_ch.ready;
   end

endmodule

[design/tcw_ctrl.sv]
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  ctl_status_type ctl_status,
   output ctl_cmd_type    ctl_cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in          = state_ff;
      ctl_cmd.req_ready = 1'b0;
      ctl_cmd.req_load  = 1'b0;
      ctl_cmd.wr_sel    = WR_NONE;
      ctl_cmd.rd_sel    = RD_REPORT;
      ctl_cmd.cur_op    = CUR_HOLD;
      ctl_cmd.idx_op    = IDX_HOLD;
      ctl_cmd.out_load  = 1'b0;
      case (state_ff)
         // clearing pass after reset
         ST_INIT: begin
            ctl_cmd.wr_sel = WR_INIT;
            if (ctl_status.idx_end) begin
               state_in = ST_IDLE;
            end else begin
               ctl_cmd.idx_op = IDX_INC;
            end
         end
         ST_IDLE: begin
            ctl_cmd.req_ready = 1'b1;
            ctl_cmd.req_load  = ctl_status.req_valid;
            if (ctl_status.req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ST_REPORT;
            case (ctl_status.cmd)
               CMD_PUT: begin
                  if (ctl_status.is_newline) begin
                     ctl_cmd.cur_op = CUR_NEWLINE;
                  end else begin
                     ctl_cmd.wr_sel = WR_CHAR;
                     ctl_cmd.cur_op = CUR_ADVANCE;
                  end
                  if ((ctl_status.is_newline || ctl_status.col_last) &&
                      ctl_status.row_last) begin
                     ctl_cmd.idx_op = IDX_ZERO;
                     state_in       = ST_SCROLL_RD;
                  end
               end
               CMD_BACKSPACE: begin
                  if (!ctl_status.line_empty) begin
                     if (!ctl_status.col_zero) begin
                        ctl_cmd.cur_op = CUR_BACK;
                        state_in       = ST_BS_NULL;
                     end else if (!ctl_status.row_zero) begin
                        ctl_cmd.cur_op = CUR_UP;
                        state_in       = ST_SCAN_RD;
                     end else begin
                        ctl_cmd.wr_sel = WR_NULL;
                     end
                  end
               end
               CMD_CLEAR: begin
                  ctl_cmd.idx_op = IDX_ZERO;
                  state_in       = ST_FILL;
               end
               default: ;
            endcase
         end
         // backward scan of the previous row
         ST_SCAN_RD: begin
            ctl_cmd.rd_sel = RD_SCAN;
            state_in       = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (ctl_status.scan_hit || ctl_status.scan_at_one) begin
               ctl_cmd.cur_op = CUR_SETCOL;
               state_in       = ST_BS_NULL;
            end else begin
               ctl_cmd.cur_op = CUR_SCAN_DEC;
               state_in       = ST_SCAN_RD;
            end
         end
         ST_BS_NULL: begin
            ctl_cmd.wr_sel = WR_NULL;
            state_in       = ST_REPORT;
         end
         // scroll: copy each cell one row up
         ST_SCROLL_RD: begin
            ctl_cmd.rd_sel = RD_SRC;
            state_in       = ST_SCROLL_WR;
         end
         ST_SCROLL_WR: begin
            ctl_cmd.wr_sel = WR_COPY;
            if (ctl_status.idx_copy_end) begin
               ctl_cmd.idx_op = IDX_BOTTOM;
               state_in       = ST_FILL;
            end else begin
               ctl_cmd.idx_op = IDX_INC;
               state_in       = ST_SCROLL_RD;
            end
         end
         // blank cells up to the last one
         ST_FILL: begin
            ctl_cmd.wr_sel = WR_BLANK;
            if (ctl_status.idx_end) begin
               state_in = ST_REPORT;
            end else begin
               ctl_cmd.idx_op = IDX_INC;
            end
         end
         ST_REPORT: begin
            ctl_cmd.rd_sel = RD_REPORT;
            state_in       = ST_RESULT;
         end
         // wait for a free result register
         ST_RESULT: begin
            if (!ctl_status.out_full) begin
               ctl_cmd.out_load = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[tb/sv/text_console_writer_top_test.sv]
module text_console_writer_top_test;
   import tcw_pkg::*;

   localparam int COLS = DEF_COLS;
   localparam int ROWS = DEF_ROWS;
   localparam int CELLS = COLS * ROWS;

   // command code the block leaves unused, it only reports
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int SETTLE_CYCLES = 50;
   localparam int HOLD_CYCLES = 150;
   localparam int MAX_REPORTED = 10;
   // slowest run is a scroll on every command; the limit allows for it
   localparam longint RUN_LIMIT = 64'd200_000_000;

   typedef struct packed {
      logic [6:0]  col;
      logic [4:0]  row;
      logic [10:0] pos;
      logic [7:0]  ch;
      logic [7:0]  attr;
   } console_report_type;

   logic clock;
   logic reset;

   tcw_req_if req_ch();
   tcw_rsp_if rsp_ch();
   tcw_csr_if csr_ch();

   text_console_writer_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow copy of the console: cells are {attribute, character}
   logic [15:0] shadow_screen [CELLS];
   logic [6:0]  shadow_col;
   logic [4:0]  shadow_row;
   logic [7:0]  shadow_attr;

   console_report_type expected_reports[$];

   int  commands_sent = 0;
   int  reports_seen = 0;
   int  report_errors = 0;
   int  scroll_count = 0;
   int  clear_count = 0;
   int  scan_count = 0;
   bit  sender_idles = 1'b1;
   bit  receiver_stalls = 1'b1;
   bit  hold_output = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // console model
   function automatic void blank_screen();
      for (int i = 0; i < CELLS; i++) shadow_screen[i] = {shadow_attr, BLANK_CHAR};
   endfunction

   function automatic void scroll_screen();
      for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = {shadow_attr, BLANK_CHAR};
      scroll_count++;
   endfunction

   function automatic void advance_line();
      shadow_col = '0;
      if (shadow_row == ROWS - 1) begin
         scroll_screen();
      end else begin
         shadow_row++;
      end
   endfunction

   function automatic int cursor_index();
      return shadow_row * COLS + shadow_col;
   endfunction

   function automatic console_report_type apply_command(logic [1:0] cmd, logic [7:0] ch,
                                                        logic empty, logic [10:0] addr);
      console_report_type rep;
      int                 x;
      logic [7:0]         seen;
      logic [15:0]        cell_word;
      case (cmd)
         CMD_PUT: begin
            if (ch == NL_CHAR || ch == CR_CHAR) begin
               advance_line();
            end else begin
               shadow_screen[cursor_index()] = {shadow_attr, ch};
               if (shadow_col == COLS - 1) begin
                  advance_line();
               end else begin
                  shadow_col++;
               end
            end
         end
         CMD_BACKSPACE: begin
            if (!empty) begin
               if (shadow_col != 0) begin
                  shadow_col--;
               end else if (shadow_row != 0) begin
                  // back up to the last printed cell of the previous row
                  shadow_row--;
                  x = COLS - 1;
                  while (x > 0) begin
                     seen = shadow_screen[shadow_row * COLS + x][7:0];
                     if (seen != NULL_CHAR && seen != BLANK_CHAR) break;
                     x--;
                  end
                  shadow_col = 7'(x);
                  scan_count++;
               end
               shadow_screen[cursor_index()] = {shadow_attr, NULL_CHAR};
            end
         end
         CMD_CLEAR: begin
            blank_screen();
            clear_count++;
         end
         default: ;
      endcase
      cell_word = (addr < CELLS) ? shadow_screen[addr] : 16'h0000;
      rep.col = shadow_col;
      rep.row = shadow_row;
      rep.pos = 11'(cursor_index());
      rep.ch = cell_word[7:0];
      rep.attr = cell_word[15:8];
      return rep;
   endfunction

   // random choices
   function automatic int pick_idle(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [10:0] pick_read_addr();
      int here;
      int r;
      here = cursor_index();
      r = $urandom_range(0, 9);
      if (r < 4) return 11'(here);
      if (r < 5) return 11'((here > 0) ? here - 1 : 0);
      if (r < 9) return 11'($urandom_range(0, CELLS - 1));
      return 11'($urandom_range(CELLS, 2047));
   endfunction

   function automatic logic [7:0] pick_text_char();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return NULL_CHAR;
      if (r == 1) return BLANK_CHAR;
      if (r == 2) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(33, 126));
   endfunction

   // one request transfer, then predict its report
   task automatic send_command(logic [1:0] cmd, logic [7:0] ch, logic empty,
                               logic [10:0] addr);
      int idle;
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.char_code <= ch;
      req_ch.line_empty <= empty;
      req_ch.read_addr <= addr;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_reports.push_back(apply_command(cmd, ch, empty, addr));
      commands_sent++;
      idle = pick_idle(sender_idles);
      if (idle > 0) begin
         req_ch.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
   endtask

   task automatic wait_for_reports();
      req_ch.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   // attribute writes only while the block is idle
   task automatic write_attribute(logic [7:0] value);
      wait_for_reports();
      csr_ch.valid <= 1'b1;
      csr_ch.wdata <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      shadow_attr = value;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // command runs
   task automatic text_run(int count);
      for (int i = 0; i < count; i++)
         send_command(CMD_PUT, pick_text_char(), 1'($urandom_range(0, 1)), pick_read_addr());
   endtask

   task automatic newline_run(int count);
      for (int i = 0; i < count; i++)
         send_command(CMD_PUT, $urandom_range(0, 1) ? NL_CHAR : CR_CHAR,
                      1'($urandom_range(0, 1)), pick_read_addr());
   endtask

   task automatic backspace_run(int count);
      for (int i = 0; i < count; i++)
         send_command(CMD_BACKSPACE, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 7) == 0), pick_read_addr());
   endtask

   task automatic noise_run(int count);
      for (int i = 0; i < count; i++)
         send_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)));
   endtask

   // tests
   task automatic test_idle_reports();
      send_command(CMD_UNUSED, 8'hFF, 1'b1, 11'd0);
      send_command(CMD_UNUSED, 8'h00, 1'b0, 11'(CELLS - 1));
      send_command(CMD_UNUSED, 8'hFF, 1'b0, 11'(CELLS));
      send_command(CMD_UNUSED, 8'h00, 1'b1, 11'h7FF);
   endtask

   task automatic test_put_characters();
      write_attribute(8'hFF);
      send_command(CMD_PUT, 8'h00, 1'b0, 11'd0);
      send_command(CMD_PUT, 8'hFF, 1'b1, 11'd1);
      send_command(CMD_PUT, 8'h41, 1'b0, 11'd2);
      send_command(CMD_PUT, NL_CHAR, 1'b0, 11'd2);
      send_command(CMD_PUT, CR_CHAR, 1'b0, 11'(COLS));
   endtask

   task automatic test_backspace();
      // ignored on an empty line
      send_command(CMD_BACKSPACE, 8'h00, 1'b1, 11'd0);
      // previous row all blank: lands on column 0
      send_command(CMD_BACKSPACE, 8'h00, 1'b0, 11'(COLS));
      // previous row holds text: lands on its last printed cell
      send_command(CMD_BACKSPACE, 8'hFF, 1'b0, 11'd2);
      send_command(CMD_BACKSPACE, 8'h00, 1'b0, 11'd1);
      send_command(CMD_BACKSPACE, 8'h00, 1'b0, 11'd0);
      // top left corner: cursor stays
      send_command(CMD_BACKSPACE, 8'h00, 1'b0, 11'd0);
   endtask

   task automatic test_clear_screen();
      write_attribute(8'h5A);
      send_command(CMD_PUT, 8'h5A, 1'b0, 11'd0);
      send_command(CMD_CLEAR, 8'h00, 1'b0, 11'd0);
      send_command(CMD_UNUSED, 8'h00, 1'b0, 11'(CELLS - 1));
   endtask

   task automatic test_output_backpressure();
      wait_for_reports();
      sender_idles = 1'b0;
      hold_output = 1'b1;
      text_run(6);
      wait_for_reports();
      sender_idles = 1'b1;
   endtask

   task automatic test_wrap_and_scroll();
      // wrap inside the grid, walk down to the last row, then wrap and newline there
      text_run(COLS + $urandom_range(0, 20));
      while (shadow_row != ROWS - 1) newline_run(1);
      text_run(COLS + $urandom_range(0, 20));
      newline_run(1);
   endtask

   task automatic test_random_mix(int count, logic [7:0] attr, bit send_idle, bit recv_stall);
      int start;
      int r;
      write_attribute(attr);
      sender_idles = send_idle;
      receiver_stalls = recv_stall;
      start = commands_sent;
      while (commands_sent - start < count) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            text_run($urandom_range(5, 90));
         end else if (r < 50) begin
            newline_run($urandom_range(1, 6));
         end else if (r < 75) begin
            backspace_run($urandom_range(1, 8));
         end else if (r < 97) begin
            noise_run($urandom_range(1, 4));
         end else begin
            send_command(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         pick_read_addr());
         end
      end
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // result receiver: random stalls, plus a long counted hold on request
   initial begin : result_receiver
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_output) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
         end else begin
            stall = ($urandom_range(0, 3) == 0) ? pick_idle(receiver_stalls) : 0;
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end else begin
               rsp_ch.ready <= 1'b1;
               @(posedge clock);
            end
         end
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : report_checker
      console_report_type got;
      console_report_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.col = rsp_ch.cursor_col;
         got.row = rsp_ch.cursor_row;
         got.pos = rsp_ch.cursor_pos;
         got.ch = rsp_ch.read_char;
         got.attr = rsp_ch.read_attr;
         reports_seen++;
         if (expected_reports.size() == 0) begin
            report_errors++;
            if (report_errors <= MAX_REPORTED)
               $display("report %0d arrived with none pending: col %0d row %0d pos %0d",
                        reports_seen, got.col, got.row, got.pos);
         end else begin
            want = expected_reports.pop_front();
            if (got.col !== want.col || got.row !== want.row || got.pos !== want.pos ||
                got.ch !== want.ch || got.attr !== want.attr) begin
               report_errors++;
               if (report_errors <= MAX_REPORTED)
                  $display({"report %0d wrong: expected col %0d row %0d pos %0d char %h ",
                            "attr %h, got col %0d row %0d pos %0d char %h attr %h"},
                           reports_seen, want.col, want.row, want.pos, want.ch, want.attr,
                           got.col, got.row, got.pos, got.ch, got.attr);
            end
         end
      end
   end

   // run limit
   initial begin : run_limit
      #(RUN_LIMIT);
      $display("timed out with %0d reports outstanding", expected_reports.size());
      $display("text_console_writer_top: mismatch");
      $finish;
   end

   // test sequence
   initial begin : test_sequence
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_PUT;
      req_ch.char_code <= 8'h00;
      req_ch.line_empty <= 1'b0;
      req_ch.read_addr <= 11'd0;
      csr_ch.valid <= 1'b0;
      csr_ch.wdata <= 8'h00;
      shadow_attr = RESET_ATTR;
      shadow_col = '0;
      shadow_row = '0;
      blank_screen();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_idle_reports();
      test_put_characters();
      test_backspace();
      test_clear_screen();
      test_output_backpressure();
      test_wrap_and_scroll();
      test_random_mix(50, 8'h00, 1'b1, 1'b1);
      test_random_mix(40, 8'($urandom_range(1, 254)), 1'b0, 1'b0);
      test_random_mix(50, 8'hFF, 1'b1, 1'b0);
      test_random_mix(40, RESET_ATTR, 1'b0, 1'b1);

      wait_for_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d console commands, checked %0d reports (%0d bad)",
               commands_sent, reports_seen, report_errors);
      $display("exercised %0d scrolls, %0d clears and %0d backspace row scans",
               scroll_count, clear_count, scan_count);
      if (report_errors == 0 && expected_reports.size() == 0) begin
         $display("text_console_writer_top: match");
      end else begin
         $display("text_console_writer_top: mismatch");
      end
      $finish;
   end

endmodule
